### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bptc_pkg.sv
// ----------------------------------------------------------------------------
// Barometer compensation package
// Field widths, output ranges, register indexes and shared types.
// ----------------------------------------------------------------------------
package bptc_pkg;

  localparam int RAW_W         = 16;
  localparam int TEMP_W        = 15;
  localparam int PRES_W        = 17;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 16;

  localparam int TEMP_MIN = -10000;
  localparam int TEMP_MAX = 15000;
  localparam int PRES_MIN = 0;
  localparam int PRES_MAX = 131071;

  localparam int TEMP_BASE     = 250;
  localparam int PRES_BIAS     = 7168;
  localparam int OFF_COEF_BIAS = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS_BASE        = 3'd0,
    REG_OFFSET_BASE      = 3'd1,
    REG_SENS_TEMP_COEF   = 3'd2,
    REG_OFFSET_TEMP_COEF = 3'd3,
    REG_REFERENCE_TEMP   = 3'd4,
    REG_TEMP_SLOPE       = 3'd5,
    REG_PRESSURE_ADJUST  = 3'd6,
    REG_CURVATURE_PARAMS = 3'd7
  } cfg_reg_e;

  // Load enables of the three stages of a rounding and clamping unit.
  typedef struct packed {
    logic mul;
    logic rnd;
    logic clip;
  } cen_en_t;

endpackage

### design/bptc_in_if.sv
// ----------------------------------------------------------------------------
// Raw reading channel
// Valid/ready channel carrying one raw temperature and pressure pair.
// ----------------------------------------------------------------------------
interface bptc_in_if;

  logic                           valid;
  logic                           ready;
  logic [bptc_pkg::RAW_W-1:0]     raw_temp;
  logic [bptc_pkg::RAW_W-1:0]     raw_pres;

  modport source (output valid, output raw_temp, output raw_pres, input ready);
  modport sink   (input valid, input raw_temp, input raw_pres, output ready);

endinterface

### design/bptc_out_if.sv
// ----------------------------------------------------------------------------
// Compensated result channel
// Valid/ready channel carrying compensated temperature and pressure.
// ----------------------------------------------------------------------------
interface bptc_out_if;

  logic                                valid;
  logic                                ready;
  logic signed [bptc_pkg::TEMP_W-1:0]  temperature_centi;
  logic [bptc_pkg::PRES_W-1:0]         pressure_centi_hpa;
  logic                                saturated;

  modport source (output valid, output temperature_centi, output pressure_centi_hpa,
                  output saturated, input ready);
  modport sink   (input valid, input temperature_centi, input pressure_centi_hpa,
                  input saturated, output ready);

endinterface

### design/bptc_centi.sv
// ----------------------------------------------------------------------------
// Rounding and clamping unit
// Three stages: scale a fixed-point 0.1 unit value by ten, round to the
// nearest integer with halves away from zero, then clamp to a range.
// ----------------------------------------------------------------------------
module bptc_centi #(
  parameter int FRAC_BITS = bptc_pkg::FRAC_BITS_DEF,
  parameter int IN_W      = 46,
  parameter int OUT_W     = bptc_pkg::TEMP_W,
  parameter int LO        = bptc_pkg::TEMP_MIN,
  parameter int HI        = bptc_pkg::TEMP_MAX
) (
  input  logic                    clk_i,
  input  bptc_pkg::cen_en_t       en_i,
  input  logic signed [IN_W-1:0]  val_i,
  output logic [OUT_W-1:0]        val_o,
  output logic                    sat_o
);

  localparam int WW = IN_W + 4;
  localparam int RW = WW - FRAC_BITS;

  localparam logic signed [WW-1:0] HALF    = WW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [WW-1:0] HALF_M1 = HALF - WW'(1);
  localparam logic signed [RW-1:0] LO_V    = RW'(LO);
  localparam logic signed [RW-1:0] HI_V    = RW'(HI);

  logic signed [WW-1:0] w_d, w_q;
  logic signed [WW-1:0] sum;
  logic signed [RW-1:0] rnd_d, rnd_q;
  logic [OUT_W-1:0]     val_d, val_q;
  logic                 sat_d, sat_q;

  assign w_d   = (WW'(val_i) <<< 3) + (WW'(val_i) <<< 1);
  assign sum   = w_q + (w_q[WW-1] ? HALF_M1 : HALF);
  assign rnd_d = $signed(sum[WW-1:FRAC_BITS]);

  always_comb begin
    if (rnd_q < LO_V) begin
      val_d = OUT_W'(LO);
      sat_d = 1'b1;
    end else if (rnd_q > HI_V) begin
      val_d = OUT_W'(HI);
      sat_d = 1'b1;
    end else begin
      val_d = rnd_q[OUT_W-1:0];
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      w_q <= w_d;
    end
    if (en_i.rnd) begin
      rnd_q <= rnd_d;
    end
    if (en_i.clip) begin
      val_q <= val_d;
      sat_q <= sat_d;
    end
  end

  assign val_o = val_q;
  assign sat_o = sat_q;

endmodule

### design/barometer_temp_pressure_compensation.sv
// ----------------------------------------------------------------------------
// Barometer temperature and pressure compensation
// Turns raw temperature and pressure readings into compensated values in
// 0.01 degC and 0.01 hPa using the sensor's calibration words, in signed
// fixed point with FRAC_BITS fractional bits.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Carries
//   in_i     sink       raw_temp, raw_pres
//   out_o    source     temperature_centi, pressure_centi_hpa, saturated
//   cfg      write      cfg_we_i, cfg_idx_i, cfg_data_i
//
// One beat enters per cycle while in_i.ready is high; each result passes
// through the 16-stage pipeline, with the last stage as the output register.
// Reset clears the stage valid bits and all calibration registers.
// A stalled output holds its beat; empty stages upstream keep filling, and
// in_i.ready falls only once all 16 stages hold a beat.
//
`include "assert_macros.svh"

module barometer_temp_pressure_compensation #(
  parameter int FRAC_BITS = bptc_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bptc_pkg::CFG_W-1:0]       cfg_data_i,
  bptc_in_if.sink                          in_i,
  bptc_out_if.source                       out_o
);

  localparam int NS   = 16;
  localparam int DW   = FRAC_BITS + 28;
  localparam int NUMW = 40;
  localparam int NXW  = NUMW + FRAC_BITS;
  localparam int PW   = DW + 17;
  localparam int TW   = DW + 2;
  localparam int SW   = DW + 8;
  localparam int OW   = DW + 6;
  localparam int XPW  = SW + 17;
  localparam int XW   = XPW - 14;
  localparam int YW   = DW + 12;
  localparam int ZW   = YW + 4;
  localparam int QW   = ZW - 5;
  localparam int P10W = DW + 12;

  localparam logic signed [TW-1:0] T_BIAS = TW'(bptc_pkg::TEMP_BASE) <<< FRAC_BITS;

  logic [15:0] sens_base_q, offset_base_q, sens_temp_coef_q, offset_temp_coef_q;
  logic [15:0] reference_temp_q, temp_slope_q, pressure_adjust_q;
  logic [31:0] curvature_params_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_base_q        <= '0;
      offset_base_q      <= '0;
      sens_temp_coef_q   <= '0;
      offset_temp_coef_q <= '0;
      reference_temp_q   <= '0;
      temp_slope_q       <= '0;
      pressure_adjust_q  <= '0;
      curvature_params_q <= '0;
    end else if (cfg_we_i) begin
      case (bptc_pkg::cfg_reg_e'(cfg_idx_i))
        bptc_pkg::REG_SENS_BASE:        sens_base_q        <= cfg_data_i[15:0];
        bptc_pkg::REG_OFFSET_BASE:      offset_base_q      <= cfg_data_i[15:0];
        bptc_pkg::REG_SENS_TEMP_COEF:   sens_temp_coef_q   <= cfg_data_i[15:0];
        bptc_pkg::REG_OFFSET_TEMP_COEF: offset_temp_coef_q <= cfg_data_i[15:0];
        bptc_pkg::REG_REFERENCE_TEMP:   reference_temp_q   <= cfg_data_i[15:0];
        bptc_pkg::REG_TEMP_SLOPE:       temp_slope_q       <= cfg_data_i[15:0];
        bptc_pkg::REG_PRESSURE_ADJUST:  pressure_adjust_q  <= cfg_data_i[15:0];
        bptc_pkg::REG_CURVATURE_PARAMS: curvature_params_q <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline control: a stage loads when out_o.ready is high or when it or any stage after it is free.
  logic [NS-1:0] vld_d, vld_q;
  logic [NS-1:0] go;
  logic          in_acc, out_acc;

  always_comb begin
    logic [NS-1:0] low_mask;
    for (int i = 0; i < NS; i++) begin
      low_mask = (NS'(1) << i) - NS'(1);
      go[i]    = out_o.ready | ~&(vld_q | low_mask);
    end
  end

  always_comb begin
    vld_d[0] = go[0] ? in_i.valid : vld_q[0];
    for (int i = 1; i < NS; i++) begin
      vld_d[i] = go[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_i.ready  = go[0];
  assign out_o.valid = vld_q[NS-1];
  assign in_acc      = in_i.valid & in_i.ready;
  assign out_acc     = out_o.valid & out_o.ready;

  logic [3:0] cs_clamp, ds_clamp;
  assign cs_clamp = (curvature_params_q[15:8] > 8'd15) ? 4'd15 : curvature_params_q[11:8];
  assign ds_clamp = (curvature_params_q[7:0] > 8'd15) ? 4'd15 : curvature_params_q[3:0];

  // Stage 1: temperature difference and curvature coefficient.
  logic signed [16:0] s1_d0_d, s1_d0_q;
  logic [7:0]         s1_k_d, s1_k_q;
  logic [15:0]        s1_rp_q;

  assign s1_d0_d = $signed({1'b0, in_i.raw_temp}) - $signed({1'b0, reference_temp_q});
  assign s1_k_d  = s1_d0_d[16] ? curvature_params_q[23:16] : curvature_params_q[31:24];

  always_ff @(posedge clk_i) begin
    if (go[0]) begin
      s1_d0_q <= s1_d0_d;
      s1_k_q  <= s1_k_d;
      s1_rp_q <= in_i.raw_pres;
    end
  end

  // Stage 2: square of the difference.
  logic signed [33:0] s2_sq_full;
  logic [31:0]        s2_sq_q;
  logic signed [16:0] s2_d0_q;
  logic [7:0]         s2_k_q;
  logic [15:0]        s2_rp_q;

  assign s2_sq_full = 34'(s1_d0_q) * 34'(s1_d0_q);

  always_ff @(posedge clk_i) begin
    if (go[1]) begin
      s2_sq_q <= s2_sq_full[31:0];
      s2_d0_q <= s1_d0_q;
      s2_k_q  <= s1_k_q;
      s2_rp_q <= s1_rp_q;
    end
  end

  // Stage 3: curvature numerator.
  logic [NUMW-1:0]    s3_num_d, s3_num_q;
  logic signed [16:0] s3_d0_q;
  logic [15:0]        s3_rp_q;

  assign s3_num_d = {8'd0, s2_sq_q} * {32'd0, s2_k_q};

  always_ff @(posedge clk_i) begin
    if (go[2]) begin
      s3_num_q <= s3_num_d;
      s3_d0_q  <= s2_d0_q;
      s3_rp_q  <= s2_rp_q;
    end
  end

  // Stage 4: corrected difference dUT.
  logic [NXW-1:0]       s4_corr;
  logic [4:0]           s4_shamt;
  logic signed [DW-1:0] s4_d0_fx;
  logic signed [DW-1:0] s4_dut_d, s4_dut_q;
  logic [15:0]          s4_rp_q;

  assign s4_shamt = 5'd14 + {1'b0, cs_clamp};
  assign s4_corr  = {s3_num_q, {FRAC_BITS{1'b0}}} >> s4_shamt;
  assign s4_d0_fx = $signed({{(DW-17-FRAC_BITS){s3_d0_q[16]}}, s3_d0_q, {FRAC_BITS{1'b0}}});
  assign s4_dut_d = s4_d0_fx - $signed(s4_corr[DW-1:0]);

  always_ff @(posedge clk_i) begin
    if (go[3]) begin
      s4_dut_q <= s4_dut_d;
      s4_rp_q  <= s3_rp_q;
    end
  end

  // Stage 5: coefficient products and dUT scaled down by 2^D.
  logic signed [16:0]   s5_c6, s5_c3, s5_c4m;
  logic [15:0]          s5_mask;
  logic signed [PW-1:0] s5_pt_d, s5_pt_q, s5_ps_d, s5_ps_q, s5_po_d, s5_po_q;
  logic signed [DW-1:0] s5_dq_d, s5_dq_q;
  logic [15:0]          s5_rp_q;

  assign s5_c6   = $signed({1'b0, temp_slope_q});
  assign s5_c3   = $signed({1'b0, sens_temp_coef_q});
  assign s5_c4m  = $signed({1'b0, offset_temp_coef_q}) - 17'(bptc_pkg::OFF_COEF_BIAS);
  assign s5_pt_d = PW'(s4_dut_q) * PW'(s5_c6);
  assign s5_ps_d = PW'(s4_dut_q) * PW'(s5_c3);
  assign s5_po_d = PW'(s4_dut_q) * PW'(s5_c4m);
  assign s5_mask = ~(16'hFFFF << ds_clamp);
  assign s5_dq_d = (s4_dut_q + $signed({{(DW-16){1'b0}}, s4_dut_q[DW-1] ? s5_mask : 16'h0000}))
                   >>> ds_clamp;

  always_ff @(posedge clk_i) begin
    if (go[4]) begin
      s5_pt_q <= s5_pt_d;
      s5_ps_q <= s5_ps_d;
      s5_po_q <= s5_po_d;
      s5_dq_q <= s5_dq_d;
      s5_rp_q <= s4_rp_q;
    end
  end

  // Stage 6: products truncated toward zero.
  logic signed [PW-1:0]    s6_pt_sum, s6_ps_sum, s6_po_sum;
  logic signed [PW-17:0]   s6_ptt_q;
  logic signed [PW-11:0]   s6_pst_q;
  logic signed [PW-15:0]   s6_pot_q;
  logic signed [DW-1:0]    s6_dq_q;
  logic [15:0]             s6_rp_q;

  assign s6_pt_sum = s5_pt_q + $signed({{(PW-16){1'b0}}, {16{s5_pt_q[PW-1]}}});
  assign s6_ps_sum = s5_ps_q + $signed({{(PW-10){1'b0}}, {10{s5_ps_q[PW-1]}}});
  assign s6_po_sum = s5_po_q + $signed({{(PW-14){1'b0}}, {14{s5_po_q[PW-1]}}});

  always_ff @(posedge clk_i) begin
    if (go[5]) begin
      s6_ptt_q <= $signed(s6_pt_sum[PW-1:16]);
      s6_pst_q <= $signed(s6_ps_sum[PW-1:10]);
      s6_pot_q <= $signed(s6_po_sum[PW-1:14]);
      s6_dq_q  <= s5_dq_q;
      s6_rp_q  <= s5_rp_q;
    end
  end

  // Stage 7: temperature, sensitivity and offset.
  logic signed [TW-1:0] s7_t10_d, s7_t10_q;
  logic signed [SW-1:0] s7_sens_d, s7_sens_q;
  logic signed [OW-1:0] s7_off_sum, s7_off_d, s7_off_q;
  logic [15:0]          s7_rp_q;

  assign s7_t10_d   = T_BIAS + TW'(s6_ptt_q) - TW'(s6_dq_q);
  assign s7_sens_d  = SW'($signed({1'b0, sens_base_q, {FRAC_BITS{1'b0}}})) + SW'(s6_pst_q);
  assign s7_off_sum = OW'($signed({1'b0, offset_base_q, {FRAC_BITS{1'b0}}})) + OW'(s6_pot_q);
  assign s7_off_d   = s7_off_sum <<< 2;

  always_ff @(posedge clk_i) begin
    if (go[6]) begin
      s7_t10_q  <= s7_t10_d;
      s7_sens_q <= s7_sens_d;
      s7_off_q  <= s7_off_d;
      s7_rp_q   <= s6_rp_q;
    end
  end

  // Temperature rounding and clamping, stages 8 to 10.
  bptc_pkg::cen_en_t       t_en;
  logic [bptc_pkg::TEMP_W-1:0] t_centi;
  logic                    t_sat;

  assign t_en.mul  = go[7];
  assign t_en.rnd  = go[8];
  assign t_en.clip = go[9];

  bptc_centi #(
    .FRAC_BITS (FRAC_BITS),
    .IN_W      (TW),
    .OUT_W     (bptc_pkg::TEMP_W),
    .LO        (bptc_pkg::TEMP_MIN),
    .HI        (bptc_pkg::TEMP_MAX)
  ) u_temp_centi (
    .clk_i (clk_i),
    .en_i  (t_en),
    .val_i (s7_t10_q),
    .val_o (t_centi),
    .sat_o (t_sat)
  );

  // Stage 8: pressure product.
  logic signed [16:0]    s8_rpm;
  logic signed [XPW-1:0] s8_xp_d, s8_xp_q;
  logic signed [OW-1:0]  s8_off_q;

  assign s8_rpm  = $signed({1'b0, s7_rp_q}) - 17'(bptc_pkg::PRES_BIAS);
  assign s8_xp_d = XPW'(s7_sens_q) * XPW'(s8_rpm);

  always_ff @(posedge clk_i) begin
    if (go[7]) begin
      s8_xp_q  <= s8_xp_d;
      s8_off_q <= s7_off_q;
    end
  end

  // Stage 9: truncated pressure product.
  logic signed [XPW-1:0] s9_xp_sum;
  logic signed [XW-1:0]  s9_x_q;
  logic signed [OW-1:0]  s9_off_q;

  assign s9_xp_sum = s8_xp_q + $signed({{(XPW-14){1'b0}}, {14{s8_xp_q[XPW-1]}}});

  always_ff @(posedge clk_i) begin
    if (go[8]) begin
      s9_x_q   <= $signed(s9_xp_sum[XPW-1:14]);
      s9_off_q <= s8_off_q;
    end
  end

  // Stage 10: offset removed.
  logic signed [YW-1:0] s10_y_d, s10_y_q;

  assign s10_y_d = YW'(s9_x_q) - YW'(s9_off_q);

  always_ff @(posedge clk_i) begin
    if (go[9]) begin
      s10_y_q <= s10_y_d;
    end
  end

  // Stage 11: scaled by ten.
  logic signed [ZW-1:0]        s11_z_d, s11_z_q;
  logic [bptc_pkg::TEMP_W-1:0] s11_tc_q;
  logic                        s11_tsat_q;

  assign s11_z_d = (ZW'(s10_y_q) <<< 3) + (ZW'(s10_y_q) <<< 1);

  always_ff @(posedge clk_i) begin
    if (go[10]) begin
      s11_z_q    <= s11_z_d;
      s11_tc_q   <= t_centi;
      s11_tsat_q <= t_sat;
    end
  end

  // Stage 12: divided by 2^5, truncated toward zero.
  logic signed [ZW-1:0]        s12_z_sum;
  logic signed [QW-1:0]        s12_quo_q;
  logic [bptc_pkg::TEMP_W-1:0] s12_tc_q;
  logic                        s12_tsat_q;

  assign s12_z_sum = s11_z_q + $signed({{(ZW-5){1'b0}}, {5{s11_z_q[ZW-1]}}});

  always_ff @(posedge clk_i) begin
    if (go[11]) begin
      s12_quo_q  <= $signed(s12_z_sum[ZW-1:5]);
      s12_tc_q   <= s11_tc_q;
      s12_tsat_q <= s11_tsat_q;
    end
  end

  // Stage 13: final pressure adjustment.
  logic signed [P10W-1:0]      s13_p10_d, s13_p10_q;
  logic [bptc_pkg::TEMP_W-1:0] s13_tc_q;
  logic                        s13_tsat_q;

  assign s13_p10_d = P10W'(s12_quo_q)
                   + P10W'($signed({1'b0, pressure_adjust_q, {FRAC_BITS{1'b0}}}));

  always_ff @(posedge clk_i) begin
    if (go[12]) begin
      s13_p10_q  <= s13_p10_d;
      s13_tc_q   <= s12_tc_q;
      s13_tsat_q <= s12_tsat_q;
    end
  end

  // Pressure rounding and clamping, stages 14 to 16.
  bptc_pkg::cen_en_t           p_en;
  logic [bptc_pkg::PRES_W-1:0] p_centi;
  logic                        p_sat;

  assign p_en.mul  = go[13];
  assign p_en.rnd  = go[14];
  assign p_en.clip = go[15];

  bptc_centi #(
    .FRAC_BITS (FRAC_BITS),
    .IN_W      (P10W),
    .OUT_W     (bptc_pkg::PRES_W),
    .LO        (bptc_pkg::PRES_MIN),
    .HI        (bptc_pkg::PRES_MAX)
  ) u_pres_centi (
    .clk_i (clk_i),
    .en_i  (p_en),
    .val_i (s13_p10_q),
    .val_o (p_centi),
    .sat_o (p_sat)
  );

  logic [bptc_pkg::TEMP_W-1:0] s14_tc_q, s15_tc_q, s16_tc_q;
  logic                        s14_tsat_q, s15_tsat_q, s16_tsat_q;

  always_ff @(posedge clk_i) begin
    if (go[13]) begin
      s14_tc_q   <= s13_tc_q;
      s14_tsat_q <= s13_tsat_q;
    end
    if (go[14]) begin
      s15_tc_q   <= s14_tc_q;
      s15_tsat_q <= s14_tsat_q;
    end
    if (go[15]) begin
      s16_tc_q   <= s15_tc_q;
      s16_tsat_q <= s15_tsat_q;
    end
  end

  assign out_o.temperature_centi  = $signed(s16_tc_q);
  assign out_o.pressure_centi_hpa = p_centi;
  assign out_o.saturated          = s16_tsat_q | p_sat;

  `ASSERT_IMPLIES(a_ready_low_full, !in_i.ready, (&vld_q) && !out_o.ready, "ready low with a free stage")
  `ASSERT_NEXT(a_occupancy, 1'b1, $countones(vld_q) == $past($countones(vld_q)) + $past(in_acc) - $past(out_acc), "pipeline lost or repeated a beat")
  `ASSERT_IMPLIES(a_temp_range, out_o.valid, (out_o.temperature_centi >= bptc_pkg::TEMP_MIN) && (out_o.temperature_centi <= bptc_pkg::TEMP_MAX), "temperature beat out of range")
  `ASSERT_IMPLIES(a_sat_interior, out_o.valid && (out_o.temperature_centi > bptc_pkg::TEMP_MIN) && (out_o.temperature_centi < bptc_pkg::TEMP_MAX) && (out_o.pressure_centi_hpa != 17'd0) && (out_o.pressure_centi_hpa != 17'h1FFFF), !out_o.saturated, "saturation flag set on an unclamped beat")

endmodule
